### rtl/iexu_pkg.sv
// shared types, codes and constants of the integer execute unit
package iexu_pkg;

	localparam int XLEN        = 64;
	localparam int REG_COUNT   = 31;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [4:0] ZERO_REG = 5'd31;

	// instruction codes as they arrive on the mode field
	typedef enum logic [4:0] {
		M_HALT   = 5'd0,
		M_ADD_I  = 5'd1,
		M_ADDS_I = 5'd2,
		M_SUB_I  = 5'd3,
		M_SUBS_I = 5'd4,
		M_ADD_R  = 5'd5,
		M_ADDS_R = 5'd6,
		M_SUB_R  = 5'd7,
		M_SUBS_R = 5'd8,
		M_AND    = 5'd9,
		M_BIC    = 5'd10,
		M_ORR    = 5'd11,
		M_ORN    = 5'd12,
		M_EOR    = 5'd13,
		M_EON    = 5'd14,
		M_ANDS   = 5'd15,
		M_BICS   = 5'd16,
		M_MADD   = 5'd17,
		M_MSUB   = 5'd18,
		M_MOVZ   = 5'd19,
		M_MOVN   = 5'd20,
		M_MOVK   = 5'd21,
		M_BEQ    = 5'd22,
		M_BNE    = 5'd23,
		M_BGE    = 5'd24,
		M_BLT    = 5'd25,
		M_BGT    = 5'd26,
		M_BLE    = 5'd27,
		M_B      = 5'd28,
		M_BR     = 5'd29,
		M_NOP    = 5'd30,
		M_NOP_ALT = 5'd31
	} mode_e;

	typedef enum logic [3:0] {
		OP_HALT, OP_ADDSUB, OP_LOGIC, OP_MUL, OP_MOV, OP_BCOND, OP_B, OP_BR, OP_NOP
	} op_class_e;

	typedef enum logic [1:0] {LOG_AND, LOG_ORR, LOG_EOR} logic_op_e;
	typedef enum logic [1:0] {MOV_Z, MOV_N, MOV_K} mov_kind_e;
	typedef enum logic [2:0] {COND_EQ, COND_NE, COND_GE, COND_LT, COND_GT, COND_LE} cond_e;
	typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shift_e;

	// classified instruction word held between front and back
	typedef struct packed {
		op_class_e          cls;
		logic               wide;
		logic [4:0]         rd;
		logic [4:0]         rm;
		logic [4:0]         ra;
		logic [4:0]         addr_a;
		logic               use_imm;
		logic               sub;
		logic               setf;
		logic_op_e          lop;
		logic               invert;
		mov_kind_e          mov;
		cond_e              cond;
		shift_e             skind;
		logic [5:0]         samt;
		logic [15:0]        imm;
		logic               immhi;
		logic [1:0]         hw;
		logic signed [25:0] offset;
	} uop_t;

	// retired result word
	typedef struct packed {
		logic            wen;
		logic [4:0]      widx;
		logic [XLEN-1:0] wval;
		logic            n;
		logic            z;
		logic            c;
		logic            v;
		logic [XLEN-1:0] next_pc;
		logic            halted;
	} result_t;

endpackage

### rtl/iexu_fifo.sv
// small first-in first-out queue of words
module iexu_fifo #(
	parameter int Depth = 2,
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             empty
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [0:Depth-1];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// word storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/iexu_front.sv
// front end: accepts instruction words, classifies them and queues them
module iexu_front import iexu_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         mode,
	input  logic               wide,
	input  logic [4:0]         dest_register,
	input  logic [4:0]         first_source,
	input  logic [4:0]         second_source,
	input  logic [4:0]         addend_source,
	input  logic [1:0]         shift_kind,
	input  logic [5:0]         shift_distance,
	input  logic [15:0]        unsigned_immediate,
	input  logic               immediate_high,
	input  logic [1:0]         halfword_select,
	input  logic signed [25:0] branch_offset,
	input  logic               push,
	output logic               full,
	output logic               head_valid,
	output uop_t               head_uop,
	input  logic               head_pop
);
	uop_t                  uop;
	logic [$bits(uop_t)-1:0] head_bits;
	logic                  q_empty;

	// decode the mode into an operation class and its controls
	always_comb begin
		uop.cls     = OP_NOP;
		uop.wide    = wide;
		uop.rd      = dest_register;
		uop.rm      = second_source;
		uop.ra      = addend_source;
		uop.addr_a  = first_source;
		uop.use_imm = 1'b0;
		uop.sub     = 1'b0;
		uop.setf    = 1'b0;
		uop.lop     = LOG_AND;
		uop.invert  = 1'b0;
		uop.mov     = MOV_Z;
		uop.cond    = COND_EQ;
		uop.skind   = shift_e'(shift_kind);
		uop.samt    = shift_distance;
		uop.imm     = unsigned_immediate;
		uop.immhi   = immediate_high;
		uop.hw      = halfword_select;
		uop.offset  = branch_offset;
		case (mode_e'(mode))
			M_HALT:   uop.cls = OP_HALT;
			M_ADD_I:  begin uop.cls = OP_ADDSUB; uop.use_imm = 1'b1; end
			M_ADDS_I: begin uop.cls = OP_ADDSUB; uop.use_imm = 1'b1; uop.setf = 1'b1; end
			M_SUB_I:  begin uop.cls = OP_ADDSUB; uop.use_imm = 1'b1; uop.sub = 1'b1; end
			M_SUBS_I: begin
				uop.cls = OP_ADDSUB; uop.use_imm = 1'b1; uop.sub = 1'b1; uop.setf = 1'b1;
			end
			M_ADD_R:  uop.cls = OP_ADDSUB;
			M_ADDS_R: begin uop.cls = OP_ADDSUB; uop.setf = 1'b1; end
			M_SUB_R:  begin uop.cls = OP_ADDSUB; uop.sub = 1'b1; end
			M_SUBS_R: begin uop.cls = OP_ADDSUB; uop.sub = 1'b1; uop.setf = 1'b1; end
			M_AND:    uop.cls = OP_LOGIC;
			M_BIC:    begin uop.cls = OP_LOGIC; uop.invert = 1'b1; end
			M_ORR:    begin uop.cls = OP_LOGIC; uop.lop = LOG_ORR; end
			M_ORN:    begin uop.cls = OP_LOGIC; uop.lop = LOG_ORR; uop.invert = 1'b1; end
			M_EOR:    begin uop.cls = OP_LOGIC; uop.lop = LOG_EOR; end
			M_EON:    begin uop.cls = OP_LOGIC; uop.lop = LOG_EOR; uop.invert = 1'b1; end
			M_ANDS:   begin uop.cls = OP_LOGIC; uop.setf = 1'b1; end
			M_BICS:   begin uop.cls = OP_LOGIC; uop.invert = 1'b1; uop.setf = 1'b1; end
			M_MADD:   uop.cls = OP_MUL;
			M_MSUB:   begin uop.cls = OP_MUL; uop.sub = 1'b1; end
			M_MOVZ:   uop.cls = OP_MOV;
			M_MOVN:   begin uop.cls = OP_MOV; uop.mov = MOV_N; end
			M_MOVK:   begin uop.cls = OP_MOV; uop.mov = MOV_K; uop.addr_a = dest_register; end
			M_BEQ:    uop.cls = OP_BCOND;
			M_BNE:    begin uop.cls = OP_BCOND; uop.cond = COND_NE; end
			M_BGE:    begin uop.cls = OP_BCOND; uop.cond = COND_GE; end
			M_BLT:    begin uop.cls = OP_BCOND; uop.cond = COND_LT; end
			M_BGT:    begin uop.cls = OP_BCOND; uop.cond = COND_GT; end
			M_BLE:    begin uop.cls = OP_BCOND; uop.cond = COND_LE; end
			M_B:      uop.cls = OP_B;
			M_BR:     uop.cls = OP_BR;
			default:  uop.cls = OP_NOP;
		endcase
	end

	// queue toward the back end
	iexu_fifo #(
		.Depth (Depth),
		.Width ($bits(uop_t))
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (uop),
		.full   (full),
		.pop    (head_pop),
		.rdata  (head_bits),
		.empty  (q_empty)
	);

	assign head_uop   = uop_t'(head_bits);
	assign head_valid = !q_empty;

endmodule

### rtl/iexu_back.sv
// back end: register file, flags, program counter and execution
module iexu_back import iexu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  uop_t    head_uop,
	output logic    head_pop,
	output logic    res_push,
	output result_t res_word,
	input  logic    res_full
);
	// register file and its read stage
	logic [XLEN-1:0] mem_q [0:REG_COUNT-1];
	logic [31:0]     reg_valid_q;
	logic [XLEN-1:0] rda_s1;
	logic [XLEN-1:0] rdb_s1;
	logic            za_s1;
	logic            zb_s1;
	uop_t            uop_s1;
	logic            s1_valid_q;

	// architectural state
	logic [XLEN-1:0] pc_q;
	logic [3:0]      flags_q;

	// shared multiplier sequence
	logic [1:0]      mul_cnt_q;
	logic [XLEN-1:0] mul_a_q;
	logic [XLEN-1:0] mul_b_q;
	logic [XLEN-1:0] prod_q;
	logic [31:0]     cross_q;
	logic [XLEN-1:0] acc_q;
	logic [XLEN-1:0] prod_lo;

	logic            load;
	logic            retire;
	logic            mul_c0;
	logic [4:0]      addr_a;
	logic [4:0]      addr_b;
	logic            we;
	logic [XLEN-1:0] a_full;
	logic [XLEN-1:0] a_op;
	logic [XLEN-1:0] b_op;
	logic [XLEN-1:0] shifted;
	logic [XLEN-1:0] opnd_b;
	logic [XLEN-1:0] sum_raw;
	logic [XLEN-1:0] as_res;
	logic [XLEN-1:0] lg_b;
	logic [XLEN-1:0] lg_raw;
	logic [XLEN-1:0] product;
	logic [XLEN-1:0] mul_raw;
	logic [5:0]      mv_sh;
	logic [XLEN-1:0] placed;
	logic [XLEN-1:0] mv_raw;
	logic [XLEN-1:0] raw;
	logic [XLEN-1:0] result;
	logic            writes;
	logic            wen;
	logic            sgn_r;
	logic            sgn_a;
	logic            sgn_b;
	logic            carry;
	logic            ovf;
	logic            take;
	logic [XLEN-1:0] target;
	logic [XLEN-1:0] pc_next;
	logic [3:0]      flags_next;
	logic [2*XLEN-1:0] rot64;
	logic [63:0]     rot32;
	logic [4:0]      asr_amt;

	// stage control
	assign mul_c0   = s1_valid_q && (uop_s1.cls == OP_MUL) && (mul_cnt_q == 2'd0);
	assign retire   = s1_valid_q && !res_full && ((uop_s1.cls != OP_MUL) || (mul_cnt_q == 2'd3));
	assign load     = head_valid && (!s1_valid_q || retire);
	assign head_pop = load;
	assign addr_a   = load ? head_uop.addr_a : uop_s1.addr_a;
	assign addr_b   = mul_c0 ? uop_s1.ra : (load ? head_uop.rm : uop_s1.rm);

	// operands, masked to 32 bits for narrow operations
	always_comb begin
		a_full = za_s1 ? '0 : rda_s1;
		a_op   = uop_s1.wide ? a_full : {32'b0, a_full[31:0]};
		b_op   = zb_s1 ? '0 : rdb_s1;
		if (!uop_s1.wide) begin
			b_op = {32'b0, b_op[31:0]};
		end
	end

	// shifter on the second register operand
	always_comb begin
		rot64   = {b_op, b_op} >> uop_s1.samt;
		rot32   = {b_op[31:0], b_op[31:0]} >> uop_s1.samt[4:0];
		asr_amt = uop_s1.samt[5] ? 5'd31 : uop_s1.samt[4:0];
		if (uop_s1.wide) begin
			case (uop_s1.skind)
				SH_LSL:  shifted = b_op << uop_s1.samt;
				SH_LSR:  shifted = b_op >> uop_s1.samt;
				SH_ASR:  shifted = XLEN'($signed(b_op) >>> uop_s1.samt);
				default: shifted = rot64[XLEN-1:0];
			endcase
		end else begin
			case (uop_s1.skind)
				SH_LSL: shifted = uop_s1.samt[5] ? '0 :
					{32'b0, 32'(b_op[31:0] << uop_s1.samt[4:0])};
				SH_LSR: shifted = uop_s1.samt[5] ? '0 :
					{32'b0, b_op[31:0] >> uop_s1.samt[4:0]};
				SH_ASR: shifted = {32'b0, 32'($signed(b_op[31:0]) >>> asr_amt)};
				default: shifted = {32'b0, rot32[31:0]};
			endcase
		end
	end

	// add and subtract with flags
	always_comb begin
		opnd_b = uop_s1.use_imm ?
			(uop_s1.immhi ? {40'b0, uop_s1.imm[11:0], 12'b0} : {52'b0, uop_s1.imm[11:0]}) :
			shifted;
		sum_raw = uop_s1.sub ? (a_op - opnd_b) : (a_op + opnd_b);
		as_res  = uop_s1.wide ? sum_raw : {32'b0, sum_raw[31:0]};
		sgn_a   = uop_s1.wide ? a_op[63] : a_op[31];
		sgn_b   = uop_s1.wide ? opnd_b[63] : opnd_b[31];
		sgn_r   = uop_s1.wide ? as_res[63] : as_res[31];
		if (uop_s1.sub) begin
			carry = (a_op >= opnd_b);
			ovf   = (sgn_a ^ sgn_b) && (sgn_a ^ sgn_r);
		end else begin
			carry = (as_res < a_op);
			ovf   = !(sgn_a ^ sgn_b) && (sgn_a ^ sgn_r);
		end
	end

	// logical operations, moves and the multiply-accumulate sum
	always_comb begin
		lg_b = uop_s1.invert ? ~shifted : shifted;
		case (uop_s1.lop)
			LOG_ORR: lg_raw = a_op | lg_b;
			LOG_EOR: lg_raw = a_op ^ lg_b;
			default: lg_raw = a_op & lg_b;
		endcase
		mv_sh  = {uop_s1.hw, 4'b0};
		placed = {48'b0, uop_s1.imm} << mv_sh;
		case (uop_s1.mov)
			MOV_N:   mv_raw = ~placed;
			MOV_K:   mv_raw = (a_op & ~({48'b0, 16'hFFFF} << mv_sh)) | placed;
			default: mv_raw = placed;
		endcase
		product = prod_q + {cross_q, 32'b0};
		mul_raw = uop_s1.sub ? (acc_q - product) : (acc_q + product);
	end

	// result select, zero extension and write enable
	always_comb begin
		case (uop_s1.cls)
			OP_ADDSUB: raw = as_res;
			OP_LOGIC:  raw = lg_raw;
			OP_MUL:    raw = mul_raw;
			OP_MOV:    raw = mv_raw;
			default:   raw = '0;
		endcase
		result = uop_s1.wide ? raw : {32'b0, raw[31:0]};
		writes = (uop_s1.cls == OP_ADDSUB) || (uop_s1.cls == OP_LOGIC) ||
			(uop_s1.cls == OP_MUL) || (uop_s1.cls == OP_MOV);
		wen    = writes && (uop_s1.rd != ZERO_REG);
		we     = retire && wen;
	end

	// flags after the instruction
	always_comb begin
		flags_next = flags_q;
		if (uop_s1.setf && (uop_s1.cls == OP_ADDSUB)) begin
			flags_next = {sgn_r, (as_res == '0), carry, ovf};
		end else if (uop_s1.setf && (uop_s1.cls == OP_LOGIC)) begin
			flags_next = {(uop_s1.wide ? result[63] : result[31]), (result == '0), 2'b00};
		end
	end

	// branch condition and next program counter
	always_comb begin
		case (uop_s1.cond)
			COND_EQ: take = flags_q[2];
			COND_NE: take = !flags_q[2];
			COND_GE: take = (flags_q[3] == flags_q[0]);
			COND_LT: take = (flags_q[3] != flags_q[0]);
			COND_GT: take = !flags_q[2] && (flags_q[3] == flags_q[0]);
			default: take = flags_q[2] || (flags_q[3] != flags_q[0]);
		endcase
		target = pc_q + {{36{uop_s1.offset[25]}}, uop_s1.offset, 2'b00};
		case (uop_s1.cls)
			OP_HALT:  pc_next = pc_q;
			OP_BCOND: pc_next = take ? target : pc_q + 64'd4;
			OP_B:     pc_next = target;
			OP_BR:    pc_next = a_full;
			default:  pc_next = pc_q + 64'd4;
		endcase
	end

	// result word toward the output queue
	always_comb begin
		res_word.wen     = wen;
		res_word.widx    = wen ? uop_s1.rd : 5'd0;
		res_word.wval    = wen ? result : '0;
		res_word.n       = flags_next[3];
		res_word.z       = flags_next[2];
		res_word.c       = flags_next[1];
		res_word.v       = flags_next[0];
		res_word.next_pc = pc_next;
		res_word.halted  = (uop_s1.cls == OP_HALT);
	end
	assign res_push = retire;

	// register file write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[uop_s1.rd] <= result;
		end
	end

	// register file read ports with write bypass
	always_ff @(posedge clk) begin
		rda_s1 <= (we && (uop_s1.rd == addr_a)) ? result : mem_q[addr_a];
		rdb_s1 <= (we && (uop_s1.rd == addr_b)) ? result : mem_q[addr_b];
		za_s1  <= (addr_a == ZERO_REG) || (!reg_valid_q[addr_a] && !(we && (uop_s1.rd == addr_a)));
		zb_s1  <= (addr_b == ZERO_REG) || (!reg_valid_q[addr_b] && !(we && (uop_s1.rd == addr_b)));
	end

	// instruction held in the read stage
	always_ff @(posedge clk) begin
		if (load) begin
			uop_s1 <= head_uop;
		end
	end

	// full 64-bit product of the two low halves
	assign prod_lo = a_op[31:0] * b_op[31:0];

	// multiplier datapath: low half of the product from three 32x32 partials
	always_ff @(posedge clk) begin
		case (mul_cnt_q)
			2'd0: begin
				mul_a_q <= a_op;
				mul_b_q <= b_op;
				prod_q  <= prod_lo;
			end
			2'd1: begin
				acc_q   <= b_op;
				cross_q <= 32'(mul_a_q[63:32] * mul_b_q[31:0]);
			end
			2'd2: cross_q <= cross_q + 32'(mul_a_q[31:0] * mul_b_q[63:32]);
			default: ;
		endcase
	end

	// control state, architectural state and register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			mul_cnt_q   <= 2'd0;
			pc_q        <= '0;
			flags_q     <= 4'b0;
			reg_valid_q <= '0;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
			end else if (retire) begin
				s1_valid_q <= 1'b0;
			end
			if (retire) begin
				mul_cnt_q <= 2'd0;
				pc_q      <= pc_next;
				flags_q   <= flags_next;
			end else if (s1_valid_q && (uop_s1.cls == OP_MUL) && (mul_cnt_q != 2'd3)) begin
				mul_cnt_q <= mul_cnt_q + 2'd1;
			end
			if (we) begin
				reg_valid_q[uop_s1.rd] <= 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_retire_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		retire |-> s1_valid_q)
		else $error("retire without a word in the read stage");
	a_mul_cnt_only_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_cnt_q != 2'd0) |-> (s1_valid_q && (uop_s1.cls == OP_MUL)))
		else $error("multiply sequence running without a multiply word");
	a_zero_reg_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (uop_s1.rd != ZERO_REG))
		else $error("write to the zero register");
	a_mul_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && (uop_s1.cls == OP_MUL) && !retire) |=> $stable(uop_s1))
		else $error("read stage changed during a multiply");
	a_zero_valid_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!reg_valid_q[31])
		else $error("zero register marked as written");
`endif

endmodule

### rtl/integer_execute_unit.sv
// top level of the integer execute unit
//
// Instruction words enter through a queue-style port: a word is taken at a
// rising edge where push is high and full is low. Results leave the same way:
// while empty is low the oldest result sits on the result ports and is taken
// at an edge where pop is high. Every instruction gives exactly one result.
// A word moves from the front queue into the read stage; when it retires its
// result is pushed into the result queue. Throughput: one word per cycle while
// the result queue has room; madd and msub hold the execute stage until the
// product is built from three 32x32 partial products and accumulated.
// The front end classifies words into a short queue; the back end reads the
// two-port register file, executes and writes the result queue. A full result
// queue stalls only the back end, the front queue keeps taking words until it
// fills. Reset marks all 31 registers unwritten, so they read as zero, and
// clears flags and PC at once, empties both queues; no clearing pass is needed.
module integer_execute_unit import iexu_pkg::*; #(
	parameter int FrontDepth  = QUEUE_DEPTH,
	parameter int ResultDepth = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         mode,
	input  logic               wide,
	input  logic [4:0]         dest_register,
	input  logic [4:0]         first_source,
	input  logic [4:0]         second_source,
	input  logic [4:0]         addend_source,
	input  logic [1:0]         shift_kind,
	input  logic [5:0]         shift_distance,
	input  logic [15:0]        unsigned_immediate,
	input  logic               immediate_high,
	input  logic [1:0]         halfword_select,
	input  logic signed [25:0] branch_offset,
	input  logic               push,
	output logic               full,
	output logic               reg_write_enable,
	output logic [4:0]         reg_write_index,
	output logic [63:0]        reg_write_value,
	output logic               flag_negative,
	output logic               flag_zero,
	output logic               flag_carry,
	output logic               flag_overflow,
	output logic [63:0]        next_pc,
	output logic               halted,
	output logic               empty,
	input  logic               pop
);
	logic                       head_valid;
	uop_t                       head_uop;
	logic                       head_pop;
	logic                       res_push;
	result_t                    res_word;
	logic                       res_full;
	logic [$bits(result_t)-1:0] out_bits;
	result_t                    out_word;

	// front end
	iexu_front #(
		.Depth (FrontDepth)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.mode               (mode),
		.wide               (wide),
		.dest_register      (dest_register),
		.first_source       (first_source),
		.second_source      (second_source),
		.addend_source      (addend_source),
		.shift_kind         (shift_kind),
		.shift_distance     (shift_distance),
		.unsigned_immediate (unsigned_immediate),
		.immediate_high     (immediate_high),
		.halfword_select    (halfword_select),
		.branch_offset      (branch_offset),
		.push               (push),
		.full               (full),
		.head_valid         (head_valid),
		.head_uop           (head_uop),
		.head_pop           (head_pop)
	);

	// back end
	iexu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_uop   (head_uop),
		.head_pop   (head_pop),
		.res_push   (res_push),
		.res_word   (res_word),
		.res_full   (res_full)
	);

	// result queue
	iexu_fifo #(
		.Depth (ResultDepth),
		.Width ($bits(result_t))
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_word),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_bits),
		.empty  (empty)
	);

	// unpack the oldest result word
	assign out_word         = result_t'(out_bits);
	assign reg_write_enable = out_word.wen;
	assign reg_write_index  = out_word.widx;
	assign reg_write_value  = out_word.wval;
	assign flag_negative    = out_word.n;
	assign flag_zero        = out_word.z;
	assign flag_carry       = out_word.c;
	assign flag_overflow    = out_word.v;
	assign next_pc          = out_word.next_pc;
	assign halted           = out_word.halted;

endmodule

### tb/integer_execute_unit_tb.sv
// self-checking testbench for the integer execute unit
module integer_execute_unit_tb;
	import iexu_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic [4:0]  mode;
		logic        wide;
		logic [4:0]  rd;
		logic [4:0]  rn;
		logic [4:0]  rm;
		logic [4:0]  ra;
		logic [1:0]  skind;
		logic [5:0]  samt;
		logic [15:0] imm;
		logic        immhi;
		logic [1:0]  hw;
		logic [25:0] off;
	} instr_t;

	typedef struct {
		logic        wen;
		logic [4:0]  widx;
		logic [63:0] wval;
		logic        n, z, c, v;
		logic [63:0] npc;
		logic        halted;
	} retire_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [4:0] mode = '0;
	logic wide = 1'b0;
	logic [4:0] dest_register = '0, first_source = '0, second_source = '0, addend_source = '0;
	logic [1:0] shift_kind = '0;
	logic [5:0] shift_distance = '0;
	logic [15:0] unsigned_immediate = '0;
	logic immediate_high = 1'b0;
	logic [1:0] halfword_select = '0;
	logic signed [25:0] branch_offset = '0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, reg_write_enable, flag_negative, flag_zero, flag_carry, flag_overflow;
	logic halted;
	logic [4:0] reg_write_index;
	logic [63:0] reg_write_value, next_pc;

	// architectural state mirrored by the predictor
	logic [63:0] gpr [31];
	logic [3:0]  nzcv;
	logic [63:0] pc;

	retire_t expected_retires[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int idle_cycles = 0;

	integer_execute_unit u_top (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] read_gpr(logic [4:0] idx, logic w);
		logic [63:0] val;
		val = (idx < 5'd31) ? gpr[idx] : 64'd0;
		return w ? val : {32'd0, val[31:0]};
	endfunction

	function automatic logic [63:0] shifted_operand(logic [63:0] val, logic [1:0] kind,
			logic [5:0] amt, logic w);
		logic [31:0] lo;
		int a;
		if (amt == 0)
			return val;
		if (w) begin
			case (kind)
				SH_LSL: return val << amt;
				SH_LSR: return val >> amt;
				SH_ASR: return $signed(val) >>> amt;
				default: return (val >> amt) | (val << (7'd64 - amt));
			endcase
		end
		lo = val[31:0];
		case (kind)
			SH_LSL: return (amt >= 32) ? 64'd0 : {32'd0, lo << amt};
			SH_LSR: return (amt >= 32) ? 64'd0 : {32'd0, lo >> amt};
			SH_ASR: begin
				a = (amt > 31) ? 31 : amt;
				return {32'd0, $signed(lo) >>> a};
			end
			default: begin
				a = amt & 31;
				if (a == 0)
					return {32'd0, lo};
				return {32'd0, (lo >> a) | (lo << (32 - a))};
			end
		endcase
	endfunction

	function automatic logic [63:0] add_sub_flags(logic [63:0] a, logic [63:0] b, logic sub,
			logic setf, logic w);
		logic [63:0] r, sgn;
		logic cy, ov;
		r = sub ? a - b : a + b;
		sgn = w ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
		if (!w)
			r[63:32] = '0;
		if (setf) begin
			if (sub) begin
				cy = a >= b;
				ov = (((a ^ b) & sgn) != 0) && (((a ^ r) & sgn) != 0);
			end else begin
				cy = r < a;
				ov = ((~(a ^ b) & sgn) != 0) && (((a ^ r) & sgn) != 0);
			end
			nzcv = {(r & sgn) != 0, r == 0, cy, ov};
		end
		return r;
	endfunction

	// works out the retire of one instruction and updates the mirrored state
	function automatic retire_t execute_instr(instr_t t);
		retire_t res;
		logic [63:0] a, b, r, pcn, offx, sgn, placed;
		logic writes, take, fn, fz, fv;
		int sh;
		offx = {{38{t.off[25]}}, t.off};
		pcn = pc + 64'd4;
		r = '0;
		writes = 1'b0;
		res.halted = 1'b0;
		if (t.mode == M_HALT) begin
			res.halted = 1'b1;
			pcn = pc;
		end else if (t.mode <= M_SUBS_R) begin
			a = read_gpr(t.rn, t.wide);
			if (t.mode <= M_SUBS_I)
				b = t.immhi ? {40'd0, t.imm[11:0], 12'd0} : {52'd0, t.imm[11:0]};
			else
				b = shifted_operand(read_gpr(t.rm, t.wide), t.skind, t.samt, t.wide);
			r = add_sub_flags(a, b, ((t.mode - 1) & 3) >= 2, ((t.mode - 1) & 1) != 0, t.wide);
			writes = 1'b1;
		end else if (t.mode <= M_BICS) begin
			a = read_gpr(t.rn, t.wide);
			b = shifted_operand(read_gpr(t.rm, t.wide), t.skind, t.samt, t.wide);
			if (t.mode inside {M_BIC, M_ORN, M_EON, M_BICS})
				b = ~b;
			if (t.mode inside {M_ORR, M_ORN})
				r = a | b;
			else if (t.mode inside {M_EOR, M_EON})
				r = a ^ b;
			else
				r = a & b;
			if (!t.wide)
				r[63:32] = '0;
			if (t.mode >= M_ANDS) begin
				sgn = t.wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
				nzcv = {(r & sgn) != 0, r == 0, 2'b00};
			end
			writes = 1'b1;
		end else if (t.mode <= M_MSUB) begin
			a = read_gpr(t.rn, t.wide) * read_gpr(t.rm, t.wide);
			b = read_gpr(t.ra, t.wide);
			r = (t.mode == M_MADD) ? b + a : b - a;
			if (!t.wide)
				r[63:32] = '0;
			writes = 1'b1;
		end else if (t.mode <= M_MOVK) begin
			sh = t.hw * 16;
			placed = {48'd0, t.imm} << sh;
			if (t.mode == M_MOVZ)
				r = placed;
			else if (t.mode == M_MOVN)
				r = ~placed;
			else
				r = (read_gpr(t.rd, t.wide) & ~(64'hFFFF << sh)) | placed;
			if (!t.wide)
				r[63:32] = '0;
			writes = 1'b1;
		end else if (t.mode <= M_BLE) begin
			fn = nzcv[3];
			fz = nzcv[2];
			fv = nzcv[0];
			case (t.mode)
				M_BEQ: take = fz;
				M_BNE: take = !fz;
				M_BGE: take = fn == fv;
				M_BLT: take = fn != fv;
				M_BGT: take = !fz && fn == fv;
				default: take = fz || fn != fv;
			endcase
			if (take)
				pcn = pc + (offx << 2);
		end else if (t.mode == M_B) begin
			pcn = pc + (offx << 2);
		end else if (t.mode == M_BR) begin
			pcn = read_gpr(t.rn, 1'b1);
		end
		if (writes && t.rd < 5'd31) begin
			gpr[t.rd] = r;
		end else begin
			writes = 1'b0;
			r = '0;
		end
		pc = pcn;
		res.wen = writes;
		res.widx = writes ? t.rd : 5'd0;
		res.wval = r;
		{res.n, res.z, res.c, res.v} = nzcv;
		res.npc = pcn;
		return res;
	endfunction

	function automatic instr_t random_instr();
		instr_t t;
		t.mode = 5'($urandom_range(0, 31));
		t.wide = 1'($urandom_range(0, 1));
		// small register pool so values get reused
		t.rd = ($urandom_range(0, 5) == 0) ? 5'd31 : 5'($urandom_range(0, 7));
		t.rn = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
		t.rm = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
		t.ra = 5'($urandom_range(0, 31));
		t.skind = 2'($urandom);
		t.samt = 6'($urandom);
		t.imm = 16'($urandom);
		t.immhi = 1'($urandom);
		t.hw = 2'($urandom);
		t.off = 26'($urandom);
		return t;
	endfunction

	// sends one word, waiting out full
	task automatic send_word(instr_t t);
		while ($urandom_range(1, 100) <= send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		mode <= t.mode;
		wide <= t.wide;
		dest_register <= t.rd;
		first_source <= t.rn;
		second_source <= t.rm;
		addend_source <= t.ra;
		shift_kind <= t.skind;
		shift_distance <= t.samt;
		unsigned_immediate <= t.imm;
		immediate_high <= t.immhi;
		halfword_select <= t.hw;
		branch_offset <= t.off;
		@(posedge clk);
		while (full)
			@(posedge clk);
		expected_retires.push_back(execute_instr(t));
		words_sent++;
	endtask

	task automatic send_quiet();
		push <= 1'b0;
	endtask

	function automatic instr_t blank_instr(logic [4:0] m, logic w);
		instr_t t;
		t = '{default: '0};
		t.mode = m;
		t.wide = w;
		return t;
	endfunction

	task automatic test_extremes();
		instr_t t;
		// fill registers with all-ones and sign patterns via movn / movz / movk
		t = blank_instr(M_MOVN, 1'b1);
		t.rd = 0;
		send_word(t);
		t = blank_instr(M_MOVZ, 1'b1);
		t.rd = 1;
		t.imm = 16'h8000;
		t.hw = 3;
		send_word(t);
		t = blank_instr(M_MOVK, 1'b0);
		t.rd = 2;
		t.imm = 16'hFFFF;
		t.hw = 3;
		send_word(t);
		// overflowing adds, borrowing subs, immediate high
		t = blank_instr(M_ADDS_R, 1'b1);
		t.rd = 3;
		t.rn = 1;
		t.rm = 1;
		send_word(t);
		t = blank_instr(M_SUBS_I, 1'b0);
		t.rd = 4;
		t.rn = 31;
		t.imm = 16'hFFFF;
		t.immhi = 1;
		send_word(t);
		t = blank_instr(M_ADDS_I, 1'b0);
		t.rd = 31;
		t.rn = 0;
		t.imm = 1;
		send_word(t);
		// long shifts in 32-bit mode and rotate on an add
		for (int k = 0; k < 4; k++) begin
			t = blank_instr(M_ADD_R, 1'b0);
			t.rd = 5;
			t.rn = 31;
			t.rm = 0;
			t.skind = 2'(k);
			t.samt = 6'd63;
			send_word(t);
		end
		t = blank_instr(M_BICS, 1'b1);
		t.rd = 6;
		t.rn = 0;
		t.rm = 1;
		t.skind = SH_ASR;
		t.samt = 6'd1;
		send_word(t);
		// multiplies with wrap
		t = blank_instr(M_MADD, 1'b1);
		t.rd = 7;
		t.rn = 0;
		t.rm = 0;
		t.ra = 1;
		send_word(t);
		t = blank_instr(M_MSUB, 1'b0);
		t.rd = 7;
		t.rn = 0;
		t.rm = 2;
		t.ra = 31;
		send_word(t);
		// branches at offset extremes, br to a full register, halt, unused mode
		t = blank_instr(M_B, 1'b0);
		t.off = 26'h2000000;
		send_word(t);
		t = blank_instr(M_B, 1'b0);
		t.off = 26'h1FFFFFF;
		send_word(t);
		for (int m = M_BEQ; m <= M_BLE; m++) begin
			t = blank_instr(5'(m), 1'b0);
			t.off = 26'h3FFFFFF;
			send_word(t);
		end
		t = blank_instr(M_BR, 1'b0);
		t.rn = 0;
		send_word(t);
		send_word(blank_instr(M_HALT, 1'b1));
		send_word(blank_instr(M_NOP, 1'b0));
		send_word(blank_instr(M_NOP_ALT, 1'b0));
		send_quiet();
	endtask

	task automatic test_random(int count);
		for (int k = 0; k < count; k++)
			send_word(random_instr());
		send_quiet();
	endtask

	task automatic drain();
		while (expected_retires.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// result checking
	always @(posedge clk) begin
		retire_t e;
		if (arst_n && pop && !empty) begin
			words_checked++;
			if (expected_retires.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_retires.pop_front();
				if (reg_write_enable !== e.wen) begin
					$error("reg_write_enable exp %0h got %0h", e.wen, reg_write_enable);
					errors++;
				end
				if (reg_write_index !== e.widx) begin
					$error("reg_write_index exp %0h got %0h", e.widx, reg_write_index);
					errors++;
				end
				if (reg_write_value !== e.wval) begin
					$error("reg_write_value exp %0h got %0h", e.wval, reg_write_value);
					errors++;
				end
				if (flag_negative !== e.n) begin
					$error("flag_negative exp %0h got %0h", e.n, flag_negative);
					errors++;
				end
				if (flag_zero !== e.z) begin
					$error("flag_zero exp %0h got %0h", e.z, flag_zero);
					errors++;
				end
				if (flag_carry !== e.c) begin
					$error("flag_carry exp %0h got %0h", e.c, flag_carry);
					errors++;
				end
				if (flag_overflow !== e.v) begin
					$error("flag_overflow exp %0h got %0h", e.v, flag_overflow);
					errors++;
				end
				if (next_pc !== e.npc) begin
					$error("next_pc exp %0h got %0h", e.npc, next_pc);
					errors++;
				end
				if (halted !== e.halted) begin
					$error("halted exp %0h got %0h", e.halted, halted);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk)
		pop <= ($urandom_range(1, 100) > recv_idle_pct);

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("integer_execute_unit test failed");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < 31; k++)
			gpr[k] = '0;
		nzcv = '0;
		pc = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 28;
		recv_idle_pct = 86;
		test_extremes();
		test_random(330);
		send_idle_pct = 86;
		recv_idle_pct = 28;
		test_random(330);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(340);
		drain();
		if (expected_retires.size() != 0)
			errors++;
		$display("covered %0d words, %0d results checked, all modes and shift kinds",
			words_sent, words_checked);
		if (errors == 0)
			$display("integer_execute_unit test passed");
		else
			$display("integer_execute_unit test failed");
		$finish;
	end

endmodule

### files.f
rtl/iexu_pkg.sv
rtl/iexu_fifo.sv
rtl/iexu_front.sv
rtl/iexu_back.sv
rtl/integer_execute_unit.sv
tb/integer_execute_unit_tb.sv
